FILE: sv/record_table_engine_top_assert.svh
// Assertion macros for the record table engine.
`ifndef RECORD_TABLE_ENGINE_TOP_ASSERT_SVH
`define RECORD_TABLE_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTH
`define RTE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RTE_ASSERT(label, clk, rst_n, prop, msg)
`define RTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: sv/rte_pkg.sv
// ----------------------------------------------------------------------------
// rte_pkg
// Types and constants shared by the record table engine.
// ----------------------------------------------------------------------------
package rte_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int REC_W    = 8 + 64 + 32 + 32;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_READ   = 3'd1;
    localparam logic [2:0] CMD_TOTAL  = 3'd2;
    localparam logic [2:0] CMD_SEARCH = 3'd3;
    localparam logic [2:0] CMD_SORT   = 3'd4;
    localparam logic [2:0] CMD_DELETE = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] category_tag;
        logic [31:0] date_word;
        logic [31:0] amount_cents;
        logic [7:0]  key;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  rec_id;
        logic [63:0] rec_category;
        logic [31:0] rec_date;
        logic [31:0] rec_amount;
        logic [47:0] sum_cents;
        logic [7:0]  match_count;
        logic [7:0]  fill_level;
    } out_word_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [63:0] category;
        logic [31:0] date;
        logic [31:0] amount;
    } rec_t;

    // memory port bundle from the sequencer
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        rec_t             wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

endpackage

FILE: sv/rte_ram.sv
// ----------------------------------------------------------------------------
// rte_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/rte_seq.sv
// ----------------------------------------------------------------------------
// rte_seq
// Command sequencer: walks the record memory one entry per cycle.
// ----------------------------------------------------------------------------
module rte_seq import rte_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_word_t  in_word,
    input  rec_t      rd_rec,
    output mem_req_t  mem_req,
    output logic      busy,
    output logic      done,
    output out_word_t result
);

    `include "record_table_engine_top_assert.svh"

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_SORT  = 6'b001000,
        S_SHIFT = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    localparam int CNT_W = IDX_W + 1;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;     // entry whose data arrives now
    logic [CNT_W-1:0] lim_reg, lim_next;     // sort pass limit
    logic             swapped_reg, swapped_next;
    rec_t             hold_reg, hold_next;   // carried entry in sort
    in_word_t         cmd_reg, cmd_next;
    out_word_t        res_reg, res_next;
    logic             found_reg, found_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        lim_reg     <= lim_next;
        swapped_reg <= swapped_next;
        hold_reg    <= hold_next;
        cmd_reg     <= cmd_next;
        res_reg     <= res_next;
        found_reg   <= found_next;
    end

    always_comb
    begin
        logic [CNT_W-1:0] nx;
        nx           = idx_reg + 1'b1;
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        lim_next     = lim_reg;
        swapped_next = swapped_reg;
        hold_next    = hold_reg;
        cmd_next     = cmd_reg;
        res_next     = res_reg;
        found_next   = found_reg;
        mem_req      = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = in_word;
                    res_next   = '0;
                    idx_next   = '0;
                    found_next = 1'b0;
                    mem_req.raddr = '0;
                    state_next = S_DONE;
                    case (in_word.cmd)
                        CMD_ADD:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = count_reg[IDX_W-1:0];
                                mem_req.wdata = '{id: 8'(count_reg + 1'b1),
                                    category: in_word.category_tag,
                                    date: in_word.date_word,
                                    amount: in_word.amount_cents};
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else if (9'(in_word.key) >= 9'(count_reg))
                            begin
                                res_next.status = ST_RANGE;
                            end
                            else
                            begin
                                mem_req.raddr = in_word.key[IDX_W-1:0];
                                state_next = S_READ;
                            end
                        end
                        CMD_TOTAL, CMD_SEARCH, CMD_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                if (in_word.cmd != CMD_TOTAL)
                                begin
                                    res_next.status = ST_EMPTY;
                                end
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_SORT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else if (count_reg != CNT_W'(1))
                            begin
                                lim_next     = count_reg;
                                swapped_next = 1'b0;
                                state_next   = S_SORT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ:
            begin
                res_next.rec_id       = rd_rec.id;
                res_next.rec_category = rd_rec.category;
                res_next.rec_date     = rd_rec.date;
                res_next.rec_amount   = rd_rec.amount;
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                // data for idx_reg is on rd_rec; prefetch the next entry
                mem_req.raddr = nx[IDX_W-1:0];
                case (cmd_reg.cmd)
                    CMD_TOTAL:
                    begin
                        res_next.sum_cents = res_reg.sum_cents + 48'(rd_rec.amount);
                    end
                    CMD_SEARCH:
                    begin
                        if (rd_rec.category == cmd_reg.category_tag)
                        begin
                            res_next.sum_cents   = res_reg.sum_cents + 48'(rd_rec.amount);
                            res_next.match_count = res_reg.match_count + 1'b1;
                        end
                    end
                    default:
                    begin
                        // delete: find, then move each later entry left by one
                        if (found_reg)
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = IDX_W'(idx_reg - 1'b1);
                            mem_req.wdata = rd_rec;
                        end
                        else if (rd_rec.id == cmd_reg.key)
                        begin
                            found_next = 1'b1;
                        end
                    end
                endcase
                idx_next = nx;
                if (nx == count_reg)
                begin
                    state_next = S_DONE;
                    if (cmd_reg.cmd == CMD_DELETE)
                    begin
                        if (found_reg || rd_rec.id == cmd_reg.key)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        else
                        begin
                            res_next.status = ST_NOTFOUND;
                        end
                    end
                end
            end
            S_SORT:
            begin
                // hold_reg carries the larger entry of the pass so far
                rec_t cur;
                cur = (idx_reg == '0) ? rd_rec : hold_reg;
                mem_req.raddr = nx[IDX_W-1:0];
                if (idx_reg != '0)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = IDX_W'(idx_reg - 1'b1);
                    if (hold_reg.amount > rd_rec.amount)
                    begin
                        mem_req.wdata = rd_rec;
                        swapped_next  = 1'b1;
                    end
                    else
                    begin
                        mem_req.wdata = hold_reg;
                        cur = rd_rec;
                    end
                end
                hold_next = cur;
                idx_next  = nx;
                if (nx == lim_reg)
                begin
                    // write the carried entry at the pass end
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = IDX_W'(lim_reg - 1'b1);
                mem_req.wdata = hold_reg;
                mem_req.raddr = '0;
                idx_next      = '0;
                lim_next      = lim_reg - 1'b1;
                swapped_next  = 1'b0;
                if (!swapped_reg || lim_reg == CNT_W'(2))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SORT;
                end
            end
            S_DONE:
            begin
                res_next.fill_level = 8'(count_reg);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_DONE);
    always_comb
    begin
        result = res_reg;
        result.fill_level = 8'(count_reg);
    end

    `RTE_ASSERT(a_state_onehot, clk, rst_n, $onehot(state_reg), "state not one-hot")
    `RTE_ASSERT(a_count_cap, clk, rst_n, count_reg <= CNT_W'(CAPACITY), "count over capacity")
    `RTE_ASSERT_NEXT(a_done_idle, clk, rst_n, state_reg == S_DONE, state_reg == S_IDLE,
        "done not followed by idle")

endmodule

FILE: sv/record_table_engine_top.sv
// ----------------------------------------------------------------------------
// record_table_engine_top
// Record table with add, read, total, search, sort and delete commands.
// ----------------------------------------------------------------------------
// Usage: drive a command word on cmd_in and raise start while busy is low;
// the word is taken at that edge and busy rises. One result word appears on
// result with done high for exactly one cycle, then busy falls.
// Add, and every empty-table, full or out-of-range case, go from idle
// straight to done; read passes through the read state first. Total,
// search and delete (absent id included) walk all N stored records, one
// entry per cycle through the single read port of the record memory.
// Sort runs bubble passes, each one entry shorter and closed by a shift
// state, stopping early after a pass without a swap.
// Reset clears the fill count and control; memory contents are not cleared
// and data of entries at or beyond the fill count is never used.
// The receiver cannot stall; result holds until the next command is taken.
module record_table_engine_top import rte_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_word_t  cmd_in,
    output logic      busy,
    output logic      done,
    output out_word_t result
);

    mem_req_t mem_req;
    rec_t     rd_rec;

    rte_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (rd_rec)
    );

    rte_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_word (cmd_in),
        .rd_rec  (rd_rec),
        .mem_req (mem_req),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

endmodule
